// ----- rtl/hrpe_pkg.sv -----
// ----------------------------------------------------------------------------
// hrpe_pkg
// Shared types, codes and constants of the HTTP request parameter extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package hrpe_pkg;

	localparam int PARAM_BUFFER_LEN_DEF = 32;

	localparam logic [7:0] CH_CR = 8'd13;
	localparam logic [7:0] CH_LF = 8'd10;
	localparam logic [7:0] CH_SP = 8'd32;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_G = 8'h47;
	localparam logic [7:0] CH_E = 8'h45;
	localparam logic [7:0] CH_T = 8'h54;
	localparam logic [7:0] CH_P = 8'h50;
	localparam logic [7:0] CH_O = 8'h4F;
	localparam logic [7:0] CH_S = 8'h53;

	localparam logic [2:0] GET_PREFIX_LEN = 3'd5;
	localparam logic [2:0] POST_PREFIX_LEN = 3'd6;

	localparam logic KIND_PARAM = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	localparam logic [1:0] VERDICT_REJECT = 2'd0;
	localparam logic [1:0] VERDICT_GET = 2'd1;
	localparam logic [1:0] VERDICT_POST = 2'd2;

	localparam logic [4:0] COUNT_SHOWN_MAX = 5'd31;

	typedef struct packed {
		logic       item_kind;
		logic [7:0] param_byte;
		logic [1:0] verdict;
		logic       is_index;
		logic [4:0] param_count;
	} hrpe_item_t;

	typedef struct packed {
		logic       valid;
		hrpe_item_t item;
	} hrpe_step_t;

	// Expected byte of the method prefix at position idx.
	function automatic logic [7:0] prefix_char(input logic is_post, input logic [2:0] idx);
		logic [7:0] c;
		c = 8'd0;
		if (is_post) begin
			case (idx)
				3'd0: c = CH_P;
				3'd1: c = CH_O;
				3'd2: c = CH_S;
				3'd3: c = CH_T;
				3'd4: c = CH_SP;
				3'd5: c = CH_SLASH;
				default: c = 8'd0;
			endcase
		end else begin
			case (idx)
				3'd0: c = CH_G;
				3'd1: c = CH_E;
				3'd2: c = CH_T;
				3'd3: c = CH_SP;
				3'd4: c = CH_SLASH;
				default: c = 8'd0;
			endcase
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/hrpe_if.sv -----
// ----------------------------------------------------------------------------
// hrpe_if
// Valid/ready channels for request bytes and extracted items.
// ----------------------------------------------------------------------------
`default_nettype none

interface hrpe_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_data;
	logic       start_of_request;

	modport source(output valid, data_byte, end_of_data, start_of_request, input ready);
	modport sink(input valid, data_byte, end_of_data, start_of_request, output ready);
endinterface

interface hrpe_out_if;
	logic       valid;
	logic       ready;
	logic       item_kind;
	logic [7:0] param_byte;
	logic [1:0] verdict;
	logic       is_index;
	logic [4:0] param_count;

	modport source(output valid, item_kind, param_byte, verdict, is_index, param_count,
		input ready);
	modport sink(input valid, item_kind, param_byte, verdict, is_index, param_count,
		output ready);
endinterface

`default_nettype wire

// ----- rtl/hrpe_parser.sv -----
// ----------------------------------------------------------------------------
// hrpe_parser
// Byte state machine: prefix match, GET path capture, POST header skip and
// body capture. Gives at most one result per accepted word.
// ----------------------------------------------------------------------------
`default_nettype none

module hrpe_parser import hrpe_pkg::*; #(
	parameter int PARAM_BUFFER_LEN = PARAM_BUFFER_LEN_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step_en,
	input  wire logic [7:0] data_byte,
	input  wire logic       end_of_data,
	input  wire logic       start_of_request,
	output hrpe_step_t      step
);

	localparam int CNT_W = $clog2(PARAM_BUFFER_LEN);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(PARAM_BUFFER_LEN - 1);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_MATCH,
		PH_GET_FIRST,
		PH_GET_PATH,
		PH_POST_FIRST,
		PH_POST_HDR,
		PH_POST_BODY,
		PH_DONE
	} phase_t;

	phase_t           phase_q, phase_d;
	logic [2:0]       pidx_q, pidx_d;
	logic             post_q, post_d;
	logic [1:0]       len_q, len_d;
	logic             cr_q, cr_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;

	logic [CNT_W+4:0] cnt_wide;
	logic [4:0]       cnt_shown;
	logic [2:0]       plen;

	always_comb begin
		phase_t     ph;
		logic [7:0] b;
		logic       emit_byte;
		logic       emit_verdict;
		logic [1:0] vcode;
		logic       vidx;

		b = data_byte;
		emit_byte = 1'b0;
		emit_verdict = 1'b0;
		vcode = VERDICT_REJECT;
		vidx = 1'b0;

		// a new request clears the parser before this word is handled
		ph     = start_of_request ? PH_IDLE : phase_q;
		pidx_d = start_of_request ? 3'd0 : pidx_q;
		post_d = start_of_request ? 1'b0 : post_q;
		len_d  = start_of_request ? 2'd0 : len_q;
		cr_d   = start_of_request ? 1'b0 : cr_q;
		cnt_d  = start_of_request ? '0 : cnt_q;
		phase_d = ph;
		plen = post_d ? POST_PREFIX_LEN : GET_PREFIX_LEN;

		case (ph)
			PH_IDLE: begin
				if (end_of_data) begin
					emit_verdict = 1'b1;
				end else if (b == CH_G) begin
					post_d = 1'b0;
					pidx_d = 3'd1;
					phase_d = PH_MATCH;
				end else if (b == CH_P) begin
					post_d = 1'b1;
					pidx_d = 3'd1;
					phase_d = PH_MATCH;
				end else begin
					emit_verdict = 1'b1;
				end
			end
			PH_MATCH: begin
				if (pidx_d >= plen || end_of_data || b != prefix_char(post_d, pidx_d)) begin
					emit_verdict = 1'b1;
				end else begin
					pidx_d = pidx_d + 3'd1;
					if (pidx_d == plen) begin
						len_d = 2'd0;
						cr_d = 1'b0;
						phase_d = post_d ? PH_POST_FIRST : PH_GET_FIRST;
					end
				end
			end
			PH_GET_FIRST: begin
				if (end_of_data) begin
					emit_verdict = 1'b1;
				end else if (b == CH_SP) begin
					emit_verdict = 1'b1;
					vcode = VERDICT_GET;
					vidx = 1'b1;
				end else begin
					phase_d = PH_GET_PATH;
					emit_byte = 1'b1;
				end
			end
			PH_GET_PATH: begin
				if (end_of_data || b == CH_SP) begin
					emit_verdict = 1'b1;
					vcode = VERDICT_GET;
				end else begin
					emit_byte = 1'b1;
				end
			end
			PH_POST_FIRST: begin
				if (end_of_data) begin
					emit_verdict = 1'b1;
				end else begin
					len_d = 2'd0;
					cr_d = (b == CH_CR);
					phase_d = PH_POST_HDR;
				end
			end
			PH_POST_HDR: begin
				if (end_of_data) begin
					emit_verdict = 1'b1;
				end else if (cr_d && b == CH_LF) begin
					cr_d = 1'b0;
					if (len_d == 2'd0) begin
						phase_d = PH_POST_BODY;
					end
					len_d = 2'd0;
				end else begin
					// a CR not followed by LF counts as line content
					if (cr_d && len_d != 2'd3) begin
						len_d = len_d + 2'd1;
					end
					cr_d = 1'b0;
					if (b == CH_CR) begin
						cr_d = 1'b1;
					end else if (len_d != 2'd3) begin
						len_d = len_d + 2'd1;
					end
				end
			end
			PH_POST_BODY: begin
				if (end_of_data || b == CH_CR || b == CH_LF) begin
					emit_verdict = 1'b1;
					vcode = VERDICT_POST;
				end else begin
					emit_byte = 1'b1;
				end
			end
			default: begin
			end
		endcase

		if (emit_verdict) begin
			phase_d = PH_DONE;
		end
		// drop bytes once the buffer is full
		if (emit_byte && cnt_d == CNT_FULL) begin
			emit_byte = 1'b0;
		end
		if (emit_byte) begin
			cnt_d = cnt_d + CNT_W'(1);
		end

		cnt_wide = {5'd0, cnt_d};
		cnt_shown = (cnt_wide > (CNT_W + 5)'(COUNT_SHOWN_MAX)) ? COUNT_SHOWN_MAX
			: cnt_wide[4:0];

		step.valid = emit_byte || emit_verdict;
		step.item.item_kind = emit_verdict ? KIND_VERDICT : KIND_PARAM;
		step.item.param_byte = emit_verdict ? 8'd0 : b;
		step.item.verdict = emit_verdict ? vcode : VERDICT_REJECT;
		step.item.is_index = emit_verdict && vidx;
		step.item.param_count = cnt_shown;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pidx_q <= 3'd0;
			post_q <= 1'b0;
			len_q <= 2'd0;
			cr_q <= 1'b0;
			cnt_q <= '0;
		end else if (step_en) begin
			phase_q <= phase_d;
			pidx_q <= pidx_d;
			post_q <= post_d;
			len_q <= len_d;
			cr_q <= cr_d;
			cnt_q <= cnt_d;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/http_request_param_extractor.sv -----
// ----------------------------------------------------------------------------
// http_request_param_extractor
// Extracts GET path/query bytes or POST body bytes from an HTTP request.
// ----------------------------------------------------------------------------
// Request bytes come in on rx one word per cycle while rx is ready; each word
// is handled in the cycle it is accepted and its result, if any, lands in the
// output register on tx in the next cycle. rx stays ready while that register
// is empty or being drained, so the block sustains one byte per clock while tx
// is ready. A request not cut short by start_of_request ends with one verdict
// word (reject, GET or POST); set start_of_request on the first word of the
// next request. At most PARAM_BUFFER_LEN-1 parameter bytes go out per request.
`default_nettype none

module http_request_param_extractor import hrpe_pkg::*; #(
	parameter int PARAM_BUFFER_LEN = PARAM_BUFFER_LEN_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	hrpe_in_if.sink   rx,
	hrpe_out_if.source tx
);

	hrpe_step_t step;
	hrpe_item_t out_q;
	logic       out_valid_q;
	logic       accept;

	assign rx.ready = !out_valid_q || tx.ready;
	assign accept = rx.valid && rx.ready;

	hrpe_parser #(
		.PARAM_BUFFER_LEN(PARAM_BUFFER_LEN)
	) u_parser (
		.clk             (clk),
		.arst_n          (arst_n),
		.step_en         (accept),
		.data_byte       (rx.data_byte),
		.end_of_data     (rx.end_of_data),
		.start_of_request(rx.start_of_request),
		.step            (step)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && step.valid) begin
			out_valid_q <= 1'b1;
		end else if (tx.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && step.valid) begin
			out_q <= step.item;
		end
	end

	assign tx.valid = out_valid_q;
	assign tx.item_kind = out_q.item_kind;
	assign tx.param_byte = out_q.param_byte;
	assign tx.verdict = out_q.verdict;
	assign tx.is_index = out_q.is_index;
	assign tx.param_count = out_q.param_count;

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the HTTP request parameter extractor. Request bytes
// go in as whole requests (directed corner cases, then random well-formed and
// broken GET/POST requests). A cycle-free parser model in the bench predicts
// every parameter word and verdict, and a checker on the output channel
// compares each word field by field, in order.
// ----------------------------------------------------------------------------

module tb_top;
	import hrpe_pkg::*;

	localparam int CLK_PERIOD = 4;
	localparam int BUF_LEN = PARAM_BUFFER_LEN_DEF;
	localparam int RANDOM_WORDS = 450;
	localparam longint RUN_LIMIT_NS = 800_000;

	localparam logic [39:0] GET_TEXT = {CH_G, CH_E, CH_T, CH_SP, CH_SLASH};
	localparam logic [47:0] POST_TEXT = {CH_P, CH_O, CH_S, CH_T, CH_SP, CH_SLASH};

	typedef enum logic [2:0] {
		PH_IDLE, PH_MATCH, PH_GET_FIRST, PH_GET_PATH,
		PH_POST_FIRST, PH_POST_HDR, PH_POST_BODY, PH_DONE
	} parse_phase_e;

	typedef enum logic [1:0] {DRAIN_FREE, DRAIN_RANDOM, DRAIN_PATTERN} drain_mode_e;

	logic clk = 1'b0;
	logic arst_n;

	hrpe_in_if  rx();
	hrpe_out_if tx();

	http_request_param_extractor #(.PARAM_BUFFER_LEN(BUF_LEN)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx),
		.tx(tx)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// parser model state
	parse_phase_e ps_phase;
	logic [2:0] ps_prefix_pos;
	logic ps_is_post;
	logic [1:0] ps_line_len;
	logic ps_cr;
	int ps_captured;

	hrpe_item_t due_words[$];
	logic [7:0] req_text[$];

	int error_count = 0;
	int words_sent = 0;
	int useful_words = 0;
	int words_checked = 0;
	int input_stalls = 0;
	int verdicts_seen[3] = '{0, 0, 0};

	bit gaps_on = 1'b1;
	int burst_left = 0;
	drain_mode_e drain_mode = DRAIN_FREE;
	int hold_cycles = 0;

	function automatic void clear_parse();
		ps_phase = PH_IDLE;
		ps_prefix_pos = '0;
		ps_is_post = 1'b0;
		ps_line_len = '0;
		ps_cr = 1'b0;
		ps_captured = 0;
	endfunction

	function automatic logic [4:0] shown_count();
		return (ps_captured > 31) ? COUNT_SHOWN_MAX : 5'(ps_captured);
	endfunction

	function automatic logic [7:0] method_byte(logic is_post, logic [2:0] pos);
		return is_post ? POST_TEXT[47 - 8 * pos -: 8] : GET_TEXT[39 - 8 * pos -: 8];
	endfunction

	function automatic hrpe_step_t finish_request(logic [1:0] v, logic idx);
		hrpe_step_t s;
		s.valid = 1'b1;
		s.item.item_kind = KIND_VERDICT;
		s.item.param_byte = 8'd0;
		s.item.verdict = v;
		s.item.is_index = idx;
		s.item.param_count = shown_count();
		ps_phase = PH_DONE;
		return s;
	endfunction

	function automatic hrpe_step_t capture_byte(logic [7:0] b);
		hrpe_step_t s;
		s = '0;
		// buffer full: drop the byte, count stays
		if (ps_captured + 1 >= BUF_LEN)
			return s;
		ps_captured++;
		s.valid = 1'b1;
		s.item.item_kind = KIND_PARAM;
		s.item.param_byte = b;
		s.item.verdict = VERDICT_REJECT;
		s.item.is_index = 1'b0;
		s.item.param_count = shown_count();
		return s;
	endfunction

	// Advance the parser model by one accepted word; returns the result word, if any.
	function automatic hrpe_step_t parse_word(logic [7:0] b, logic eod, logic sor);
		hrpe_step_t s;
		logic [2:0] plen;
		s = '0;
		if (sor)
			clear_parse();
		case (ps_phase)
			PH_IDLE: begin
				if (eod || (b != CH_G && b != CH_P)) begin
					s = finish_request(VERDICT_REJECT, 1'b0);
				end else begin
					ps_is_post = (b == CH_P);
					ps_prefix_pos = 3'd1;
					ps_phase = PH_MATCH;
				end
			end
			PH_MATCH: begin
				plen = ps_is_post ? POST_PREFIX_LEN : GET_PREFIX_LEN;
				if (ps_prefix_pos >= plen || eod || b != method_byte(ps_is_post, ps_prefix_pos)) begin
					s = finish_request(VERDICT_REJECT, 1'b0);
				end else begin
					ps_prefix_pos++;
					if (ps_prefix_pos == plen) begin
						ps_line_len = '0;
						ps_cr = 1'b0;
						ps_phase = ps_is_post ? PH_POST_FIRST : PH_GET_FIRST;
					end
				end
			end
			PH_GET_FIRST: begin
				if (eod)
					s = finish_request(VERDICT_REJECT, 1'b0);
				else if (b == CH_SP)
					s = finish_request(VERDICT_GET, 1'b1);
				else begin
					ps_phase = PH_GET_PATH;
					s = capture_byte(b);
				end
			end
			PH_GET_PATH: begin
				if (eod || b == CH_SP)
					s = finish_request(VERDICT_GET, 1'b0);
				else
					s = capture_byte(b);
			end
			PH_POST_FIRST: begin
				// the byte right after the prefix is not counted as line content
				if (eod)
					s = finish_request(VERDICT_REJECT, 1'b0);
				else begin
					ps_line_len = '0;
					ps_cr = (b == CH_CR);
					ps_phase = PH_POST_HDR;
				end
			end
			PH_POST_HDR: begin
				if (eod)
					s = finish_request(VERDICT_REJECT, 1'b0);
				else if (ps_cr && b == CH_LF) begin
					ps_cr = 1'b0;
					if (ps_line_len == 2'd0)
						ps_phase = PH_POST_BODY;
					ps_line_len = '0;
				end else begin
					// a bare CR counts as line content
					if (ps_cr) begin
						ps_cr = 1'b0;
						ps_line_len += 2'(ps_line_len != 2'd3);
					end
					if (b == CH_CR)
						ps_cr = 1'b1;
					else
						ps_line_len += 2'(ps_line_len != 2'd3);
				end
			end
			PH_POST_BODY: begin
				if (eod || b == CH_CR || b == CH_LF)
					s = finish_request(VERDICT_POST, 1'b0);
				else
					s = capture_byte(b);
			end
			default: ;
		endcase
		return s;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
		error_count++;
	endtask

	// Offer one word and hold it until accepted; close the burst with a gap when due.
	task automatic send_word(logic [7:0] b, logic eod, logic sor);
		hrpe_step_t s;
		rx.valid <= 1'b1;
		rx.data_byte <= b;
		rx.end_of_data <= eod;
		rx.start_of_request <= sor;
		do @(posedge clk); while (!rx.ready);
		words_sent++;
		if (ps_phase != PH_DONE || sor)
			useful_words++;
		s = parse_word(b, eod, sor);
		if (s.valid)
			due_words.push_back(s.item);
		if (gaps_on) begin
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				rx.valid <= 1'b0;
				repeat ($urandom_range(0, 9) == 0 ? $urandom_range(7, 20) : $urandom_range(1, 4))
					@(posedge clk);
				burst_left = $urandom_range(0, 12);
			end
		end
	endtask

	task automatic send_request(bit with_eod, bit with_sor);
		int i;
		for (i = 0; i < req_text.size(); i++)
			send_word(req_text[i], 1'b0, with_sor && i == 0);
		if (with_eod)
			send_word(8'($urandom), 1'b1, with_sor && req_text.size() == 0);
		req_text.delete();
	endtask

	function automatic void append_text(string s);
		int i;
		for (i = 0; i < s.len(); i++)
			req_text.push_back(s[i]);
	endfunction

	function automatic logic [7:0] rand_byte_except(logic [7:0] a, logic [7:0] b);
		logic [7:0] r;
		do r = 8'($urandom); while (r == a || r == b);
		return r;
	endfunction

	task automatic send_text(string s, bit with_eod);
		append_text(s);
		send_request(with_eod, 1'b1);
	endtask

	function automatic void append_random(int n, logic [7:0] a, logic [7:0] b);
		int i;
		for (i = 0; i < n; i++)
			req_text.push_back(rand_byte_except(a, b));
	endfunction

	// Result checker and input stall counter
	always @(posedge clk) begin
		hrpe_item_t want;
		if (arst_n && rx.valid && !rx.ready)
			input_stalls++;
		if (arst_n && tx.valid && tx.ready) begin
			if (due_words.size() == 0) begin
				report_mismatch("unexpected result word, param_count", tx.param_count, -1);
			end else begin
				want = due_words.pop_front();
				words_checked++;
				if (tx.item_kind != want.item_kind)
					report_mismatch("item_kind", tx.item_kind, want.item_kind);
				if (tx.param_byte != want.param_byte)
					report_mismatch("param_byte", tx.param_byte, want.param_byte);
				if (tx.verdict != want.verdict)
					report_mismatch("verdict", tx.verdict, want.verdict);
				if (tx.is_index != want.is_index)
					report_mismatch("is_index", tx.is_index, want.is_index);
				if (tx.param_count != want.param_count)
					report_mismatch("param_count", tx.param_count, want.param_count);
				if (want.item_kind == KIND_VERDICT && want.verdict <= VERDICT_POST)
					verdicts_seen[want.verdict]++;
			end
		end
	end

	// Receiver: long hold-off when asked, otherwise the current stall pattern
	initial begin
		logic [7:0] lfsr;
		lfsr = 8'hA5;
		tx.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				tx.ready <= 1'b0;
				hold_cycles--;
			end else begin
				case (drain_mode)
					DRAIN_FREE: tx.ready <= 1'b1;
					DRAIN_RANDOM: tx.ready <= ($urandom_range(0, 99) >= 35);
					default: begin
						lfsr = {lfsr[6:0], lfsr[7] ^ lfsr[5] ^ lfsr[4] ^ lfsr[3]};
						tx.ready <= lfsr[0] | lfsr[2];
					end
				endcase
			end
		end
	end

	task automatic test_method_matching();
		send_text("X", 1'b0);
		req_text.push_back(8'h00);
		send_request(1'b0, 1'b1);
		req_text.push_back(8'hFF);
		send_request(1'b0, 1'b1);
		send_text("", 1'b1);
		send_text("GEX", 1'b0);
		send_text("POSX", 1'b0);
		send_text("GE", 1'b1);
		send_text("GET /", 1'b1);
		send_text("POST /", 1'b1);
		// words after the verdict are dropped until the next request starts
		append_text("Q");
		send_request(1'b0, 1'b1);
		append_text("GET /zz ");
		send_request(1'b1, 1'b0);
	endtask

	task automatic test_get_paths();
		send_text("GET / ", 1'b0);
		send_text("GET /a", 1'b1);
		send_text("GET /index.html?k=v&x=1 tail", 1'b0);
		append_text("GET /");
		req_text.push_back(8'h00);
		req_text.push_back(8'hFF);
		append_text("ab ");
		send_request(1'b0, 1'b1);
		// overflow the parameter buffer
		append_text("GET /");
		append_random(40, CH_SP, CH_SP);
		append_text(" ");
		send_request(1'b0, 1'b1);
		// restart in the middle of a request
		send_text("GET /ab", 1'b0);
		send_text("GET /c ", 1'b0);
	endtask

	task automatic test_post_bodies();
		send_text("POST /a\r\n", 1'b1);
		send_text("POST /\r\nab\r", 1'b0);
		send_text("POST / HTTP/1.1\r\nHost: x\r\n\r\nk=v\n", 1'b0);
		send_text("POST / HTTP/1.1\r\nHost: x\r\n", 1'b1);
		send_text("POST /ab\rX\r\n\r\nz", 1'b1);
		append_text("POST /\r\n");
		append_random(40, CH_CR, CH_LF);
		append_text("\r");
		send_request(1'b0, 1'b1);
	endtask

	task automatic test_output_backpressure();
		int r;
		gaps_on = 1'b0;
		drain_mode = DRAIN_FREE;
		hold_cycles = 150;
		for (r = 0; r < 3; r++) begin
			append_text("GET /");
			append_random(20, CH_SP, CH_SP);
			append_text(" ");
			send_request(1'b0, 1'b1);
		end
		gaps_on = 1'b1;
	endtask

	task automatic send_random_request();
		int kind, n, h, i;
		bit with_eod;
		string pfx;
		with_eod = 1'b0;
		kind = $urandom_range(0, 99);
		if (kind < 35) begin
			append_text("GET /");
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 45) : $urandom_range(0, 12);
			append_random(n, CH_SP, CH_SP);
			if ($urandom_range(0, 2) == 0)
				with_eod = 1'b1;
			else
				append_text(" ");
		end else if (kind < 70) begin
			append_text("POST /");
			append_random($urandom_range(0, 8), CH_CR, CH_LF);
			append_text("\r\n");
			h = $urandom_range(0, 3);
			for (i = 0; i < h; i++) begin
				append_random($urandom_range(1, 6), CH_CR, CH_LF);
				if ($urandom_range(0, 6) == 0) begin
					append_text("\r");
					append_random(1, CH_LF, CH_LF);
				end
				append_text("\r\n");
			end
			append_text("\r\n");
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 40) : $urandom_range(0, 10);
			append_random(n, CH_CR, CH_LF);
			case ($urandom_range(0, 2))
				0: append_text("\r");
				1: append_text("\n");
				default: with_eod = 1'b1;
			endcase
		end else if (kind < 78) begin
			// prefix cut short by a wrong byte or end of data
			if ($urandom_range(0, 1))
				pfx = "GET /";
			else
				pfx = "POST /";
			n = $urandom_range(0, pfx.len() - 1);
			for (i = 0; i < n; i++)
				req_text.push_back(pfx[i]);
			if ($urandom_range(0, 1))
				with_eod = 1'b1;
			else
				append_random(1, pfx[n], pfx[n]);
		end else if (kind < 84) begin
			// end of data inside the POST headers
			append_text("POST /");
			append_random($urandom_range(0, 6), CH_LF, CH_LF);
			if ($urandom_range(0, 1))
				append_text("\r\nHost: y\r\n");
			with_eod = 1'b1;
		end else if (kind < 94) begin
			append_random($urandom_range(1, 8), 8'd0, 8'd0);
			with_eod = ($urandom_range(0, 1) == 1);
		end else begin
			// unfinished request, the next one restarts the parser
			if ($urandom_range(0, 1))
				append_text("GET /");
			else
				append_text("POST /x\r\n\r\n");
			append_random($urandom_range(0, 4), CH_CR, CH_SP);
		end
		// a few requests lack the start flag and are mostly dropped
		send_request(with_eod, $urandom_range(0, 29) != 0);
		if ($urandom_range(0, 4) == 0) begin
			append_random($urandom_range(1, 3), 8'd0, 8'd0);
			send_request($urandom_range(0, 1) == 1, 1'b0);
		end
	endtask

	task automatic test_random_requests(int word_target);
		int start, nreq;
		start = useful_words;
		nreq = 0;
		while (useful_words - start < word_target) begin
			if (nreq % 40 == 0) begin
				gaps_on = ($urandom_range(0, 3) != 0);
				drain_mode = drain_mode_e'($urandom_range(0, 2));
			end
			send_random_request();
			nreq++;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		rx.valid <= 1'b0;
		rx.data_byte <= 8'd0;
		rx.end_of_data <= 1'b0;
		rx.start_of_request <= 1'b0;
		clear_parse();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		drain_mode = DRAIN_RANDOM;
		test_method_matching();
		test_get_paths();
		drain_mode = DRAIN_PATTERN;
		test_post_bodies();
		test_output_backpressure();
		test_random_requests(RANDOM_WORDS);

		rx.valid <= 1'b0;
		drain_mode = DRAIN_FREE;
		while (due_words.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Sent %0d request words (%0d not dropped), checked %0d result words.",
			words_sent, useful_words, words_checked);
		$display("Verdicts: %0d reject, %0d GET, %0d POST; input stalled %0d cycles.",
			verdicts_seen[0], verdicts_seen[1], verdicts_seen[2], input_stalls);
		if (error_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("Run limit reached with %0d result words outstanding", due_words.size());
		$display("TB_ERROR");
		$finish;
	end

endmodule
